/* rtl/discrete_frechet_distance_4d_defines.svh */
// assertion macros for the frechet block
`ifndef DISCRETE_FRECHET_DISTANCE_4D_DEFINES_SVH
`define DISCRETE_FRECHET_DISTANCE_4D_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dfd_pkg.sv */
package dfd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int DIST_W         = 34;

  localparam logic CURVE_FIRST  = 1'b0;
  localparam logic CURVE_SECOND = 1'b1;

  typedef struct packed {
    logic                      curve_select;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic signed [FIELD_W-1:0] coord_w;
    logic                      final_req;
  } dfd_point_t;

  typedef struct packed {
    logic [DIST_W-1:0] squared_distance;
    logic              empty_curve;
    logic              overflow;
  } dfd_result_t;

  // marks that travel with a first-curve point along the cell row
  typedef struct packed {
    logic valid;
    logic first_row;
    logic last_row;
  } dfd_tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dfd_state_t;

endpackage

/* rtl/dfd_cell.sv */
module dfd_cell import dfd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift_en,
  input  logic [4*COORD_BITS-1:0]   q_in,
  output logic [4*COORD_BITS-1:0]   q_out,
  input  logic [4*COORD_BITS-1:0]   in_pt,
  input  dfd_tag_t                  in_tag,
  input  logic [2*COORD_BITS+2:0]   left_c,
  input  logic [2*COORD_BITS+2:0]   left_prev,
  output logic [4*COORD_BITS-1:0]   out_pt,
  output dfd_tag_t                  out_tag,
  output logic [2*COORD_BITS+2:0]   out_c,
  output logic [2*COORD_BITS+2:0]   out_prev,
  output logic                      done
);

  localparam int PW  = 4*COORD_BITS;
  localparam int SQW = 2*COORD_BITS;
  localparam int DW  = 2*COORD_BITS + 2;
  localparam int CVW = DW + 1;
  localparam logic [CVW-1:0] INF = {1'b1, {DW{1'b0}}};

  logic [PW-1:0]  q;
  logic [PW-1:0]  pt;
  dfd_tag_t       pt_tag;
  dfd_tag_t       sq_tag;
  dfd_tag_t       d_tag;
  logic [SQW-1:0] prod [4];
  logic [SQW-1:0] sq_r [4];
  logic [DW-1:0]  pair_sq;
  logic [CVW-1:0] cval;
  logic [CVW-1:0] prev;
  logic           done_r;
  logic [CVW-1:0] above;
  logic [CVW-1:0] diag;
  logic [CVW-1:0] m1;
  logic [CVW-1:0] m;
  logic [CVW-1:0] dext;
  logic [CVW-1:0] c_next;

  // held point of the second curve, shifted in from the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= q_in;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [COORD_BITS:0] diff;
    logic signed [COORD_BITS:0] neg;
    logic [COORD_BITS-1:0]      mag;
    assign diff = {in_pt[k*COORD_BITS+COORD_BITS-1], in_pt[k*COORD_BITS +: COORD_BITS]}
                - {q[k*COORD_BITS+COORD_BITS-1], q[k*COORD_BITS +: COORD_BITS]};
    assign neg  = -diff;
    assign mag  = diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
    assign prod[k] = SQW'(mag) * SQW'(mag);
  end

  always_ff @(posedge clk) begin
    pt <= in_pt;
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= prod[k];
    end
    pair_sq <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]) + DW'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_tag <= '0;
      sq_tag <= '0;
      d_tag  <= '0;
      done_r <= 1'b0;
    end else begin
      pt_tag <= in_tag;
      sq_tag <= in_tag;
      d_tag  <= sq_tag;
      done_r <= d_tag.valid & d_tag.last_row;
    end
  end

  // coupling cell: max of distance and min of above, left, diagonal
  always_comb begin
    above  = d_tag.first_row ? INF : cval;
    diag   = d_tag.first_row ? INF : left_prev;
    m1     = (above < left_c) ? above : left_c;
    m      = (m1 < diag) ? m1 : diag;
    dext   = {1'b0, pair_sq};
    c_next = m[CVW-1] ? dext : ((dext > m) ? dext : m);
  end

  always_ff @(posedge clk) begin
    if (d_tag.valid) begin
      cval <= c_next;
      prev <= cval;
    end
  end

  assign q_out    = q;
  assign out_pt   = pt;
  assign out_tag  = pt_tag;
  assign out_c    = cval;
  assign out_prev = prev;
  assign done     = done_r;

endmodule

/* rtl/dfd_feeder.sv */
module dfd_feeder import dfd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0]     wr_idx,
  input  logic [4*COORD_BITS-1:0]           wr_data,
  input  logic                              start,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
  output logic [4*COORD_BITS-1:0]           pt_out,
  output dfd_tag_t                          tag_out,
  output logic                              active
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CNW = $clog2(MAX_POINTS+1);
  localparam int PW  = 4*COORD_BITS;

  logic [PW-1:0]  mem [MAX_POINTS];
  logic [AW-1:0]  rd_idx;
  logic [CNW-1:0] n;
  logic           busy_r;
  logic           is_last;

  assign is_last = (CNW'(rd_idx) == n - CNW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    pt_out <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r  <= 1'b0;
      rd_idx  <= '0;
      n       <= '0;
      tag_out <= '0;
    end else begin
      tag_out <= '0;
      if (start) begin
        busy_r <= 1'b1;
        rd_idx <= '0;
        n      <= count;
      end else if (busy_r) begin
        tag_out.valid     <= 1'b1;
        tag_out.first_row <= (rd_idx == '0);
        tag_out.last_row  <= is_last;
        if (is_last) begin
          busy_r <= 1'b0;
        end else begin
          rd_idx <= rd_idx + AW'(1);
        end
      end
    end
  end

  assign active = busy_r;

endmodule

/* rtl/discrete_frechet_distance_4d.sv */
// Squared discrete Frechet distance of two 4D polylines. Points arrive one item per cycle
// (start high while busy is low), each tagged for the first or the second curve; up to
// MAX_POINTS points per curve are kept and further points are dropped and flagged. The
// item with final_req set is stored first, then busy rises and the coupling recurrence
// runs on a row of MAX_POINTS cells that hold the second curve, while the first curve
// streams through them from its point memory one point per cycle. The result item
// shows on result for exactly one cycle with done high; the receiver cannot stall it,
// so it must take it in that cycle. With n1 and n2 stored points, done follows the
// final item once the wavefront has crossed the n2 occupied cells for each of the n1
// streamed points, after the feeder memory read and the squared-lane, sum and value
// registers of each cell; when either curve is empty the result comes in the
// next cycle. A new item may be taken in the same cycle as done. The stores are empty
// again after every result.
`include "discrete_frechet_distance_4d_defines.svh"

module discrete_frechet_distance_4d import dfd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  dfd_point_t  point,
  output logic        done,
  output dfd_result_t result
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CNW = $clog2(MAX_POINTS+1);
  localparam int PW  = 4*COORD_BITS;
  localparam int DW  = 2*COORD_BITS + 2;
  localparam int CVW = DW + 1;
  // all-ones-top marker meaning "no predecessor" on the head cell
  localparam logic [CVW-1:0] INF = {1'b1, {DW{1'b0}}};

  dfd_state_t     state, state_next;
  logic [CNW-1:0] first_count, first_count_next;
  logic [CNW-1:0] second_count, second_count_next;
  logic           dropped, dropped_next;
  logic           done_next;
  dfd_result_t    result_next;

  logic           accept;
  logic           first_full;
  logic           second_full;
  logic           load_first;
  logic           load_second;
  logic [CNW-1:0] fc_inc;
  logic [CNW-1:0] sc_inc;
  logic           drop_in;
  logic           feed_start;
  logic [PW-1:0]  new_pt;

  logic [PW-1:0]  feed_pt;
  dfd_tag_t       feed_tag;
  logic           feed_active;

  logic [PW-1:0]  q_of    [MAX_POINTS];
  logic [PW-1:0]  pt_of   [MAX_POINTS];
  dfd_tag_t       tag_of  [MAX_POINTS];
  logic [CVW-1:0] c_of    [MAX_POINTS];
  logic [CVW-1:0] prev_of [MAX_POINTS];
  logic           tail_done;

  assign accept = start & ~busy;
  assign busy   = (state != ST_IDLE);

  // coordinates re-read as COORD_BITS two's complement, x in the low lane
  assign new_pt = {COORD_BITS'(point.coord_w), COORD_BITS'(point.coord_z),
                   COORD_BITS'(point.coord_y), COORD_BITS'(point.coord_x)};

  // a curve that is full drops the point, the final item's point too
  assign first_full  = (first_count == CNW'(MAX_POINTS));
  assign second_full = (second_count == CNW'(MAX_POINTS));
  assign load_first  = accept & (point.curve_select == CURVE_FIRST) & ~first_full;
  assign load_second = accept & (point.curve_select == CURVE_SECOND) & ~second_full;
  assign drop_in     = accept & ((point.curve_select == CURVE_SECOND) ? second_full
                                                                       : first_full);
  assign fc_inc      = first_count + CNW'(load_first);
  assign sc_inc      = second_count + CNW'(load_second);

  // control: load points, launch the sweep on final, collect the tail cell's answer
  always_comb begin
    state_next        = state;
    first_count_next  = first_count;
    second_count_next = second_count;
    dropped_next      = dropped;
    done_next         = 1'b0;
    result_next       = result;
    feed_start        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          first_count_next  = fc_inc;
          second_count_next = sc_inc;
          dropped_next      = dropped | drop_in;
          if (point.final_req) begin
            if (fc_inc == '0 || sc_inc == '0) begin
              // empty curve: answer at once and start over
              result_next.squared_distance = '0;
              result_next.empty_curve      = 1'b1;
              result_next.overflow         = dropped | drop_in;
              done_next                    = 1'b1;
              first_count_next             = '0;
              second_count_next            = '0;
              dropped_next                 = 1'b0;
            end else begin
              feed_start = 1'b1;
              state_next = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (tail_done) begin
          result_next.squared_distance = DIST_W'(c_of[MAX_POINTS-1][DW-1:0]);
          result_next.empty_curve      = 1'b0;
          result_next.overflow         = dropped;
          done_next                    = 1'b1;
          first_count_next             = '0;
          second_count_next            = '0;
          dropped_next                 = 1'b0;
          state_next                   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      dropped      <= dropped_next;
      done         <= done_next;
    end
  end

  // result payload holds between strobes
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // first curve lives in the feeder memory and is streamed out row by row
  dfd_feeder #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_feeder (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_first),
    .wr_idx  (first_count[AW-1:0]),
    .wr_data (new_pt),
    .start   (feed_start),
    .count   (fc_inc),
    .pt_out  (feed_pt),
    .tag_out (feed_tag),
    .active  (feed_active)
  );

  // cell row: second curve shifts in from the right end, so its n2 points sit in
  // the last n2 cells; the head cell (first occupied) takes the streamed points
  // and the last cell always produces the answer
  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    logic           head;
    logic [PW-1:0]  q_in;
    logic [PW-1:0]  in_pt;
    dfd_tag_t       in_tag;
    logic [CVW-1:0] left_c;
    logic [CVW-1:0] left_prev;

    assign head = (second_count == CNW'(MAX_POINTS - j));

    if (j == MAX_POINTS-1) begin : g_right
      assign q_in = new_pt;
    end else begin : g_mid
      assign q_in = q_of[j+1];
    end

    if (j == 0) begin : g_left
      assign in_pt     = feed_pt;
      assign in_tag    = head ? feed_tag : '0;
      assign left_c    = INF;
      assign left_prev = INF;
    end else begin : g_link
      assign in_pt     = head ? feed_pt : pt_of[j-1];
      assign in_tag    = head ? feed_tag : tag_of[j-1];
      assign left_c    = head ? INF : c_of[j-1];
      assign left_prev = head ? INF : prev_of[j-1];
    end

    if (j == MAX_POINTS-1) begin : g_tail
      dfd_cell #(
        .COORD_BITS (COORD_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift_en  (load_second),
        .q_in      (q_in),
        .q_out     (q_of[j]),
        .in_pt     (in_pt),
        .in_tag    (in_tag),
        .left_c    (left_c),
        .left_prev (left_prev),
        .out_pt    (pt_of[j]),
        .out_tag   (tag_of[j]),
        .out_c     (c_of[j]),
        .out_prev  (prev_of[j]),
        .done      (tail_done)
      );
    end else begin : g_body
      dfd_cell #(
        .COORD_BITS (COORD_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift_en  (load_second),
        .q_in      (q_in),
        .q_out     (q_of[j]),
        .in_pt     (in_pt),
        .in_tag    (in_tag),
        .left_c    (left_c),
        .left_prev (left_prev),
        .out_pt    (pt_of[j]),
        .out_tag   (tag_of[j]),
        .out_c     (c_of[j]),
        .out_prev  (prev_of[j]),
        .done      ()
      );
    end
  end

  // checks
  `DFD_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `DFD_ASSERT_NOW(a_counts_cap, 1'b1,
    (first_count <= CNW'(MAX_POINTS)) && (second_count <= CNW'(MAX_POINTS)),
    "point count beyond capacity")
  `DFD_ASSERT_NOW(a_tail_in_run, tail_done, state == ST_RUN, "tail answer outside a sweep")
  `DFD_ASSERT_NOW(a_feed_in_run, feed_active, state == ST_RUN, "streaming outside a sweep")

endmodule
